// File: sv/trm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trm_pkg
// Shared codes, widths and types of the tiny register machine execute block.
// ----------------------------------------------------------------------------
package trm_pkg;

  // Defaults of the top-level parameters
  localparam int unsigned NumRegsDef   = 10;
  localparam int unsigned DataWidthDef = 32;

  // Fixed field widths of the channels
  localparam int unsigned FuncW   = 4;
  localparam int unsigned FormW   = 2;
  localparam int unsigned RegIdxW = 4;
  localparam int unsigned ImmW    = 32;
  localparam int unsigned LineW   = 4;
  localparam int unsigned OutValW = 32;
  localparam int unsigned StatW   = 2;

  // Decoupling queue between front and back
  localparam int unsigned QueueDepth = 2;

  // Instruction function codes
  typedef enum logic [FuncW-1:0] {
    FUNC_ADD    = 4'd0,
    FUNC_SUB    = 4'd1,
    FUNC_MUL    = 4'd2,
    FUNC_DIV    = 4'd3,
    FUNC_MOVE   = 4'd4,
    FUNC_CMP    = 4'd5,
    FUNC_JUMP   = 4'd6,
    FUNC_BRANCH = 4'd7,
    FUNC_HALT   = 4'd8
  } func_e;

  // Operand forms
  typedef enum logic [FormW-1:0] {
    FORM_IMM_IMM = 2'd0,
    FORM_REG_REG = 2'd1,
    FORM_REG_IMM = 2'd2
  } form_e;

  // Result status codes
  typedef enum logic [StatW-1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_IDX = 2'd1,
    STAT_DIV0    = 2'd2,
    STAT_HALTED  = 2'd3
  } status_e;

  // Classified operation handed from front to back
  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_DIV    = 4'd3,
    OP_MOVE   = 4'd4,
    OP_CMP    = 4'd5,
    OP_JUMP   = 4'd6,
    OP_BRANCH = 4'd7,
    OP_HALT   = 4'd8,
    OP_NOP    = 4'd9,
    OP_BADIDX = 4'd10
  } op_e;

  // Queue entry: classified instruction
  typedef struct packed {
    op_e                op;
    logic               x_reg;   // first operand comes from register ra
    logic               y_reg;   // second operand comes from register rb
    logic [RegIdxW-1:0] ra;
    logic [RegIdxW-1:0] rb;
    logic [ImmW-1:0]    imm_a;
    logic [ImmW-1:0]    imm_b;
    logic [LineW-1:0]   line;
  } entry_t;

  // Result item as held in the output register
  typedef struct packed {
    logic                      wrote;
    logic [RegIdxW-1:0]        dest_index;
    logic signed [OutValW-1:0] dest_value;
    logic                      redirect;
    logic [LineW-1:0]          next_line;
    status_e                   status;
  } result_t;

  // Request to the shared multiply/divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

endpackage
`default_nettype wire

// File: sv/trm_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trm_in_if
// Instruction channel: valid/ready handshake with the decoded instruction.
// ----------------------------------------------------------------------------
interface trm_in_if;
  import trm_pkg::*;

  logic               valid;
  logic               ready;
  logic [FuncW-1:0]   func;
  logic [FormW-1:0]   form;
  logic [RegIdxW-1:0] first_reg;
  logic [RegIdxW-1:0] second_reg;
  logic [ImmW-1:0]    imm_a;
  logic [ImmW-1:0]    imm_b;
  logic [LineW-1:0]   target_line;

  modport source (
    output valid, func, form, first_reg, second_reg, imm_a, imm_b, target_line,
    input  ready
  );

  modport sink (
    input  valid, func, form, first_reg, second_reg, imm_a, imm_b, target_line,
    output ready
  );

endinterface
`default_nettype wire

// File: sv/trm_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trm_out_if
// Result channel: valid/ready handshake with one execution result.
// ----------------------------------------------------------------------------
interface trm_out_if;
  import trm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      wrote;
  logic [RegIdxW-1:0]        dest_index;
  logic signed [OutValW-1:0] dest_value;
  logic                      redirect;
  logic [LineW-1:0]          next_line;
  logic [StatW-1:0]          status;

  modport source (
    output valid, wrote, dest_index, dest_value, redirect, next_line, status,
    input  ready
  );

  modport sink (
    input  valid, wrote, dest_index, dest_value, redirect, next_line, status,
    output ready
  );

endinterface
`default_nettype wire

// File: sv/trm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trm_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module trm_ram #(
  parameter  int unsigned WIDTH = 32,
  parameter  int unsigned DEPTH = 10,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_a_i,
  input  wire logic [AddrW-1:0] raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule
`default_nettype wire

// File: sv/trm_muldiv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trm_muldiv
// Iterative multiply (low half, shift-add) and signed truncating divide
// (restoring, on magnitudes). One bit per cycle.
// ----------------------------------------------------------------------------
module trm_muldiv #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire trm_pkg::md_req_t      req_i,
  input  wire logic [DATA_WIDTH-1:0] a_i,
  input  wire logic [DATA_WIDTH-1:0] b_i,
  output logic                       busy_o,
  output logic [DATA_WIDTH-1:0]      result_o
);
  import trm_pkg::*;

  localparam int unsigned CntW = $clog2(DATA_WIDTH + 1);

  logic                  busy_q, busy_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  is_div_q, is_div_d;
  logic                  neg_q, neg_d;
  logic [DATA_WIDTH-1:0] opa_q, opa_d;   // multiplicand / dividend, then quotient
  logic [DATA_WIDTH-1:0] opb_q, opb_d;   // multiplier / divisor
  logic [DATA_WIDTH-1:0] acc_q, acc_d;   // product / partial remainder

  logic [DATA_WIDTH-1:0] mag_a, mag_b;
  logic [DATA_WIDTH:0]   rem_sh, diff;
  logic                  ge;

  // Magnitudes of signed operands
  assign mag_a = a_i[DATA_WIDTH-1] ? (~a_i + 1'b1) : a_i;
  assign mag_b = b_i[DATA_WIDTH-1] ? (~b_i + 1'b1) : b_i;

  // Restoring divide trial subtract
  assign rem_sh = {acc_q, opa_q[DATA_WIDTH-1]};
  assign diff   = rem_sh - {1'b0, opb_q};
  assign ge     = ~diff[DATA_WIDTH];

  always_comb begin
    busy_d   = busy_q;
    cnt_d    = cnt_q;
    is_div_d = is_div_q;
    neg_d    = neg_q;
    opa_d    = opa_q;
    opb_d    = opb_q;
    acc_d    = acc_q;
    if (req_i.start) begin
      busy_d   = 1'b1;
      cnt_d    = '0;
      is_div_d = req_i.is_div;
      neg_d    = a_i[DATA_WIDTH-1] ^ b_i[DATA_WIDTH-1];
      acc_d    = '0;
      opa_d    = req_i.is_div ? mag_a : a_i;
      opb_d    = req_i.is_div ? mag_b : b_i;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DATA_WIDTH - 1)) begin
        busy_d = 1'b0;
      end
      if (is_div_q) begin
        acc_d = ge ? diff[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
        opa_d = {opa_q[DATA_WIDTH-2:0], ge};
      end else begin
        acc_d = opb_q[0] ? (acc_q + opa_q) : acc_q;
        opa_d = {opa_q[DATA_WIDTH-2:0], 1'b0};
        opb_d = {1'b0, opb_q[DATA_WIDTH-1:1]};
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    is_div_q <= is_div_d;
    neg_q    <= neg_d;
    opa_q    <= opa_d;
    opb_q    <= opb_d;
    acc_q    <= acc_d;
  end

  assign busy_o   = busy_q;
  assign result_o = !is_div_q ? acc_q : (neg_q ? (~opa_q + 1'b1) : opa_q);

endmodule
`default_nettype wire

// File: sv/trm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trm_front
// Accepts instructions, checks register indexes and classifies each into an
// operation with its operand sources, then pushes it into the queue.
// ----------------------------------------------------------------------------
module trm_front #(
  parameter int unsigned NUM_REGS = trm_pkg::NumRegsDef
) (
  trm_in_if.sink           in_i,
  input  wire logic        q_full_i,
  output logic             q_push_o,
  output trm_pkg::entry_t  q_entry_o
);
  import trm_pkg::*;

  logic ra_ok, rb_ok, bad;
  op_e  op, arith_op;
  logic x_reg, y_reg;

  assign ra_ok = {1'b0, in_i.first_reg}  < (RegIdxW + 1)'(NUM_REGS);
  assign rb_ok = {1'b0, in_i.second_reg} < (RegIdxW + 1)'(NUM_REGS);

  // Arithmetic function to operation
  always_comb begin
    unique case (in_i.func)
      FUNC_ADD: arith_op = OP_ADD;
      FUNC_SUB: arith_op = OP_SUB;
      FUNC_MUL: arith_op = OP_MUL;
      default:  arith_op = OP_DIV;
    endcase
  end

  // Classification
  always_comb begin
    op    = OP_NOP;
    x_reg = 1'b0;
    y_reg = 1'b0;
    bad   = 1'b0;
    unique case (in_i.func) inside
      FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV: begin
        unique case (in_i.form)
          FORM_IMM_IMM: op = arith_op;
          FORM_REG_REG: begin
            op    = arith_op;
            x_reg = 1'b1;
            y_reg = 1'b1;
            bad   = !ra_ok || !rb_ok;
          end
          FORM_REG_IMM: begin
            op    = arith_op;
            x_reg = 1'b1;
            bad   = !ra_ok;
          end
          default: op = OP_NOP;
        endcase
      end
      FUNC_MOVE: begin
        unique case (in_i.form)
          FORM_REG_REG: begin
            op    = OP_MOVE;
            y_reg = 1'b1;
            bad   = !ra_ok || !rb_ok;
          end
          FORM_REG_IMM: begin
            op  = OP_MOVE;
            bad = !ra_ok;
          end
          default: op = OP_NOP;
        endcase
      end
      FUNC_CMP: begin
        op    = OP_CMP;
        x_reg = 1'b1;
        y_reg = 1'b1;
        bad   = !ra_ok || !rb_ok;
      end
      FUNC_JUMP:   op = OP_JUMP;
      FUNC_BRANCH: begin
        op    = OP_BRANCH;
        x_reg = 1'b1;
      end
      FUNC_HALT:   op = OP_HALT;
      default:     op = OP_NOP;
    endcase
  end

  // Queue push; branch reads register 0 through the first read port
  always_comb begin
    q_entry_o.op    = bad ? OP_BADIDX : op;
    q_entry_o.x_reg = x_reg;
    q_entry_o.y_reg = y_reg;
    q_entry_o.ra    = (op == OP_BRANCH) ? '0 : in_i.first_reg;
    q_entry_o.rb    = in_i.second_reg;
    q_entry_o.imm_a = in_i.imm_a;
    q_entry_o.imm_b = in_i.imm_b;
    q_entry_o.line  = in_i.target_line;
  end

  assign in_i.ready = !q_full_i;
  assign q_push_o   = in_i.valid && !q_full_i;

endmodule
`default_nettype wire

// File: sv/trm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trm_queue
// Short FIFO of classified instructions between front and back.
// ----------------------------------------------------------------------------
module trm_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire trm_pkg::entry_t entry_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output trm_pkg::entry_t      head_o
);
  import trm_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  entry_t          mem_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

endmodule
`default_nettype wire

// File: sv/trm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trm_back
// Executes classified instructions in order: register file reads, ALU or
// the iterative multiply/divide unit, register write back and the result
// output register.
// ----------------------------------------------------------------------------
module trm_back #(
  parameter int unsigned NUM_REGS   = trm_pkg::NumRegsDef,
  parameter int unsigned DATA_WIDTH = trm_pkg::DataWidthDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_empty_i,
  input  wire trm_pkg::entry_t q_head_i,
  output logic                 q_pop_o,
  trm_out_if.source            out_o
);
  import trm_pkg::*;

  localparam int unsigned AddrW = $clog2(NUM_REGS);
  localparam int unsigned ImmEW = (DATA_WIDTH > ImmW) ? DATA_WIDTH : ImmW;
  localparam int unsigned OutEW = (DATA_WIDTH > OutValW) ? DATA_WIDTH : OutValW;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_READ   = 3'b010,
    S_MULDIV = 3'b100
  } state_e;

  state_e                state_q, state_d;
  entry_t                cur_q, cur_d;
  logic                  halted_q, halted_d;
  logic [NUM_REGS-1:0]   valid_q;
  logic                  rva_q, rvb_q;
  logic                  out_valid_q, out_valid_d;
  result_t               res_q, res_d;

  logic [RegIdxW-1:0]    raddr_a, raddr_b;
  logic [DATA_WIDTH-1:0] rdata_a, rdata_b;
  logic [ImmEW-1:0]      imm_a_ext, imm_b_ext;
  logic [DATA_WIDTH-1:0] x, y;

  result_t               rd_res, fin_res;
  logic [DATA_WIDTH-1:0] rd_val, fin_val;
  logic [OutEW-1:0]      fin_val_ext;
  logic                  need_md, slot_free, fin, fin_md;
  md_req_t               md_req;
  logic                  md_busy;
  logic [DATA_WIDTH-1:0] md_result;
  logic                  we;

  // Register file reads: queue head while idle, current item otherwise
  assign raddr_a = (state_q == S_IDLE) ? q_head_i.ra : cur_q.ra;
  assign raddr_b = (state_q == S_IDLE) ? q_head_i.rb : cur_q.rb;

  trm_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (NUM_REGS)
  ) u_regfile (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (fin_res.dest_index[AddrW-1:0]),
    .wdata_i   (fin_val),
    .raddr_a_i (raddr_a[AddrW-1:0]),
    .raddr_b_i (raddr_b[AddrW-1:0]),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // Operands; a register never written reads as zero
  assign imm_a_ext = ImmEW'(cur_q.imm_a);
  assign imm_b_ext = ImmEW'(cur_q.imm_b);
  assign x = cur_q.x_reg ? (rva_q ? rdata_a : '0) : imm_a_ext[DATA_WIDTH-1:0];
  assign y = cur_q.y_reg ? (rvb_q ? rdata_b : '0) : imm_b_ext[DATA_WIDTH-1:0];

  assign need_md   = !halted_q &&
                     ((cur_q.op == OP_MUL) || ((cur_q.op == OP_DIV) && (y != '0)));
  assign slot_free = !out_valid_q || out_o.ready;

  trm_muldiv #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (md_req),
    .a_i      (x),
    .b_i      (y),
    .busy_o   (md_busy),
    .result_o (md_result)
  );

  // Combinational execution result; multiply and non-zero divide use the unit's result instead
  always_comb begin
    rd_res        = '0;
    rd_res.status = STAT_OK;
    rd_val        = '0;
    if (halted_q) begin
      rd_res.status = STAT_HALTED;
    end else begin
      unique case (cur_q.op)
        OP_ADD: begin
          rd_res.wrote = 1'b1;
          rd_val       = x + y;
        end
        OP_SUB: begin
          rd_res.wrote = 1'b1;
          rd_val       = x - y;
        end
        OP_DIV:    rd_res.status = STAT_DIV0;  // only reached with zero divisor
        OP_MOVE: begin
          rd_res.wrote      = 1'b1;
          rd_res.dest_index = cur_q.ra;
          rd_val            = y;
        end
        OP_CMP: begin
          rd_res.wrote = 1'b1;
          if (x == y) begin
            rd_val = '0;
          end else if ($signed(x) > $signed(y)) begin
            rd_val = DATA_WIDTH'(1);
          end else begin
            rd_val = '1;
          end
        end
        OP_JUMP: begin
          rd_res.redirect  = 1'b1;
          rd_res.next_line = cur_q.line;
        end
        OP_BRANCH: begin
          if (x == '0) begin
            rd_res.redirect  = 1'b1;
            rd_res.next_line = cur_q.line;
          end
        end
        OP_HALT:   rd_res.status = STAT_HALTED;
        OP_BADIDX: rd_res.status = STAT_BAD_IDX;
        default:   rd_res.status = STAT_OK;    // no-op, multiply goes to the unit
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    q_pop_o = 1'b0;
    md_req  = '0;
    fin     = 1'b0;
    fin_md  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_head_i;
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (need_md) begin
          md_req.start  = 1'b1;
          md_req.is_div = (cur_q.op == OP_DIV);
          state_d       = S_MULDIV;
        end else if (slot_free) begin
          fin     = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_MULDIV: begin
        if (!md_busy && slot_free) begin
          fin     = 1'b1;
          fin_md  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Final result and write back
  always_comb begin
    fin_res = rd_res;
    fin_val = rd_val;
    if (fin_md) begin
      fin_res        = '0;
      fin_res.status = STAT_OK;
      fin_res.wrote  = 1'b1;
      fin_val        = md_result;
    end
    fin_val_ext        = OutEW'(fin_val);
    fin_res.dest_value = fin_val_ext[OutValW-1:0];
  end

  assign we          = fin && fin_res.wrote;
  assign halted_d    = halted_q || (fin && !fin_md && (cur_q.op == OP_HALT));
  assign out_valid_d = fin ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
  assign res_d       = fin ? fin_res : res_q;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      halted_q    <= 1'b0;
      valid_q     <= '0;
      rva_q       <= 1'b0;
      rvb_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      halted_q    <= halted_d;
      out_valid_q <= out_valid_d;
      if (we) begin
        valid_q[fin_res.dest_index[AddrW-1:0]] <= 1'b1;
      end
      rva_q <= ({1'b0, raddr_a} < (RegIdxW + 1)'(NUM_REGS)) ?
               valid_q[raddr_a[AddrW-1:0]] : 1'b0;
      rvb_q <= ({1'b0, raddr_b} < (RegIdxW + 1)'(NUM_REGS)) ?
               valid_q[raddr_b[AddrW-1:0]] : 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    res_q <= res_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.wrote      = res_q.wrote;
  assign out_o.dest_index = res_q.dest_index;
  assign out_o.dest_value = res_q.dest_value;
  assign out_o.redirect   = res_q.redirect;
  assign out_o.next_line  = res_q.next_line;
  assign out_o.status     = res_q.status;

endmodule
`default_nettype wire

// File: sv/tiny_register_machine_execute.sv
// Execute stage of a tiny register machine. Each transfer on in_i is one
// decoded instruction run against NUM_REGS signed DATA_WIDTH-bit registers
// (all zero after reset); each instruction gives exactly one transfer on
// out_o, in order. The front classifies instructions into a two-entry queue,
// so in_i keeps accepting while the back works or a result waits, until the
// queue is full. The back takes one instruction at a time: S_IDLE pops it,
// S_READ reads its registers and, once the result register is free, writes
// the result; multiply and non-zero divide first run in S_MULDIV, a
// one-bit-per-cycle shift-add / restoring unit that sets the sustained rate
// for multiply/divide streams. After a halt every instruction reports halted.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tiny_register_machine_execute
// Top level: front classifier, decoupling queue and execution back end.
// ----------------------------------------------------------------------------
module tiny_register_machine_execute #(
  parameter int unsigned NUM_REGS   = trm_pkg::NumRegsDef,
  parameter int unsigned DATA_WIDTH = trm_pkg::DataWidthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  trm_in_if.sink    in_i,
  trm_out_if.source out_o
);
  import trm_pkg::*;

  logic   q_push, q_full, q_pop, q_empty;
  entry_t q_entry, q_head;

  trm_front #(
    .NUM_REGS (NUM_REGS)
  ) u_front (
    .in_i      (in_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_entry_o (q_entry)
  );

  trm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  trm_back #(
    .NUM_REGS   (NUM_REGS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule
`default_nettype wire

// File: sv/trm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trm_checker
// Port-level checks of the execute block's result channel, bound to the top.
// ----------------------------------------------------------------------------
module trm_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic                          out_wrote_i,
  input wire logic [trm_pkg::RegIdxW-1:0]   out_dest_index_i,
  input wire logic [trm_pkg::OutValW-1:0]   out_dest_value_i,
  input wire logic                          out_redirect_i,
  input wire logic [trm_pkg::LineW-1:0]     out_next_line_i,
  input wire logic [trm_pkg::StatW-1:0]     out_status_i
);
  import trm_pkg::*;

  logic halt_seen_q;

  // Remember a delivered halted result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halt_seen_q <= 1'b0;
    end else if (out_valid_i && out_ready_i && (out_status_i == STAT_HALTED)) begin
      halt_seen_q <= 1'b1;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_dest_value_i) &&
      $stable(out_status_i) && $stable(out_wrote_i))
    else $error("stalled result changed");

  // Once halted, every later result reports halted and does nothing
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && halt_seen_q |->
      (out_status_i == STAT_HALTED) && !out_wrote_i && !out_redirect_i)
    else $error("result after halt not reported as halted");

  // A write happens only on success and never together with a redirect
  a_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_wrote_i |-> (out_status_i == STAT_OK) && !out_redirect_i)
    else $error("register write with error status or redirect");

  // Fields not in use are zero
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      (out_wrote_i || ((out_dest_index_i == '0) && (out_dest_value_i == '0))) &&
      (out_redirect_i || (out_next_line_i == '0)))
    else $error("unused result field not zero");

endmodule

bind tiny_register_machine_execute trm_checker u_trm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_wrote_i      (out_o.wrote),
  .out_dest_index_i (out_o.dest_index),
  .out_dest_value_i (out_o.dest_value),
  .out_redirect_i   (out_o.redirect),
  .out_next_line_i  (out_o.next_line),
  .out_status_i     (out_o.status)
);
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tiny register machine execute stage. A table
// of directed instructions covers overflow, bad indexes, zero divisors and
// the spare codes. Random instruction streams follow under several
// sender/receiver idle mixes, including a long receiver hold-off. Every result
// transfer is checked in order against a hand-written result or an instruction-level
// register-file model; the run ends with a halt and the ignored tail after it.
// ----------------------------------------------------------------------------
module tb;
  import trm_pkg::*;

  localparam realtime     ClkPeriod     = 12.0;
  localparam int unsigned ResetCycles   = 12;
  localparam int unsigned DrainCycles   = 60;
  localparam int unsigned TimeoutCycles = 600_000;
  localparam int unsigned PhaseItems    = 250;
  localparam int unsigned HaltTailItems = 30;
  localparam int unsigned LongHold      = 400;

  // Spare codes: no-ops as functions, and as a form for arithmetic and move
  localparam logic [FormW-1:0] FormSpare   = 2'd3;
  localparam logic [FuncW-1:0] FuncSpareLo = 4'd9;
  localparam logic [FuncW-1:0] FuncSpareHi = 4'd15;

  // One decoded instruction as driven on the input channel
  typedef struct packed {
    logic [FuncW-1:0]   func;
    logic [FormW-1:0]   form;
    logic [RegIdxW-1:0] ra;
    logic [RegIdxW-1:0] rb;
    logic [ImmW-1:0]    imm_a;
    logic [ImmW-1:0]    imm_b;
    logic [LineW-1:0]   line;
  } instr_t;

  // Directed table row: fixed rows carry a hand-written result
  typedef struct {
    instr_t  ins;
    bit      fixed;
    result_t res;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  trm_in_if  in_if ();
  trm_out_if out_if ();

  tiny_register_machine_execute i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Architectural state as the instruction stream leaves it
  logic signed [OutValW-1:0] arch_regs [NumRegsDef];
  logic                      arch_halted;

  result_t     exp_results [$];
  stim_row_t   stim_rows   [$];
  int unsigned err_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned recv_hold;

  // Clock
  initial clk_i = 1'b0;
  always #(ClkPeriod / 2.0) clk_i = ~clk_i;

  // Run limit
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("[tiny_register_machine_execute] ERROR");
    $finish;
  end

  // Execute one instruction on the architectural state
  function automatic result_t exec_instr(input instr_t it);
    result_t            res;
    logic signed [31:0] x, y, v;
    logic               ra_ok, rb_ok, go;
    res        = '0;
    res.status = STAT_OK;
    ra_ok      = (it.ra < NumRegsDef);
    rb_ok      = (it.rb < NumRegsDef);
    x          = '0;
    y          = '0;
    v          = '0;
    go         = 1'b0;
    if (arch_halted) begin
      res.status = STAT_HALTED;
    end else begin
      case (it.func)
        FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV: begin
          case (it.form)
            FORM_IMM_IMM: begin
              x  = it.imm_a;
              y  = it.imm_b;
              go = 1'b1;
            end
            FORM_REG_REG: begin
              if (ra_ok && rb_ok) begin
                x  = arch_regs[it.ra];
                y  = arch_regs[it.rb];
                go = 1'b1;
              end else begin
                res.status = STAT_BAD_IDX;
              end
            end
            FORM_REG_IMM: begin
              if (ra_ok) begin
                x  = arch_regs[it.ra];
                y  = it.imm_b;
                go = 1'b1;
              end else begin
                res.status = STAT_BAD_IDX;
              end
            end
            default: ;
          endcase
          if (go) begin
            case (it.func)
              FUNC_ADD: v = x + y;
              FUNC_SUB: v = x - y;
              FUNC_MUL: v = x * y;
              default: begin
                // 64-bit quotient so that min / -1 wraps cleanly
                if (y == 0) begin
                  res.status = STAT_DIV0;
                  go         = 1'b0;
                end else begin
                  v = 32'(longint'(x) / longint'(y));
                end
              end
            endcase
          end
          if (go) begin
            arch_regs[0]   = v;
            res.wrote      = 1'b1;
            res.dest_value = v;
          end
        end
        FUNC_MOVE: begin
          if (it.form == FORM_REG_REG || it.form == FORM_REG_IMM) begin
            if (!ra_ok || (it.form == FORM_REG_REG && !rb_ok)) begin
              res.status = STAT_BAD_IDX;
            end else begin
              v = (it.form == FORM_REG_REG) ? arch_regs[it.rb] : it.imm_b;
              arch_regs[it.ra] = v;
              res.wrote        = 1'b1;
              res.dest_index   = it.ra;
              res.dest_value   = v;
            end
          end
        end
        FUNC_CMP: begin
          // form is ignored, always register against register
          if (!ra_ok || !rb_ok) begin
            res.status = STAT_BAD_IDX;
          end else begin
            x = arch_regs[it.ra];
            y = arch_regs[it.rb];
            if (x == y) v = 0;
            else if (x > y) v = 1;
            else v = -1;
            arch_regs[0]   = v;
            res.wrote      = 1'b1;
            res.dest_value = v;
          end
        end
        FUNC_JUMP: begin
          res.redirect  = 1'b1;
          res.next_line = it.line;
        end
        FUNC_BRANCH: begin
          if (arch_regs[0] == 0) begin
            res.redirect  = 1'b1;
            res.next_line = it.line;
          end
        end
        FUNC_HALT: begin
          arch_halted = 1'b1;
          res.status  = STAT_HALTED;
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  function automatic instr_t mk_instr(input logic [FuncW-1:0] func, input logic [FormW-1:0] form,
                                      input logic [RegIdxW-1:0] ra, input logic [RegIdxW-1:0] rb,
                                      input logic [ImmW-1:0] imm_a, input logic [ImmW-1:0] imm_b,
                                      input logic [LineW-1:0] line);
    instr_t it;
    it.func  = func;
    it.form  = form;
    it.ra    = ra;
    it.rb    = rb;
    it.imm_a = imm_a;
    it.imm_b = imm_b;
    it.line  = line;
    return it;
  endfunction

  function automatic result_t mk_res(input logic wrote, input logic [RegIdxW-1:0] idx,
                                     input logic [OutValW-1:0] val, input logic redir,
                                     input logic [LineW-1:0] line, input status_e st);
    result_t r;
    r.wrote      = wrote;
    r.dest_index = idx;
    r.dest_value = val;
    r.redirect   = redir;
    r.next_line  = line;
    r.status     = st;
    return r;
  endfunction

  task automatic row_fix(input instr_t it, input result_t res);
    stim_rows.push_back('{ins: it, fixed: 1'b1, res: res});
  endtask

  task automatic row_chk(input instr_t it);
    stim_rows.push_back('{ins: it, fixed: 1'b0, res: '0});
  endtask

  // Operand values: extremes, small signed values, full-range noise
  function automatic logic [ImmW-1:0] rand_val();
    int s;
    s = int'($urandom_range(40)) - 20;
    case ($urandom_range(7))
      0:       return '0;
      1:       return 32'd1;
      2:       return '1;
      3:       return 32'h8000_0000;
      4:       return 32'h7fff_ffff;
      5, 6:    return s;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [RegIdxW-1:0] rand_idx();
    if ($urandom_range(99) < 8) return 4'($urandom_range(15, NumRegsDef));
    return 4'($urandom_range(NumRegsDef - 1));
  endfunction

  // Mostly valid instructions, moves weighted up to keep registers varied
  function automatic instr_t rand_instr();
    instr_t      it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 6) it.func = 4'($urandom_range(FuncSpareHi, FuncSpareLo));
    else if (pick < 26) it.func = FUNC_MOVE;
    else it.func = 4'($urandom_range(FUNC_BRANCH));
    it.form  = ($urandom_range(99) < 6) ? FormSpare : 2'($urandom_range(FORM_REG_IMM));
    it.ra    = rand_idx();
    it.rb    = rand_idx();
    it.imm_a = rand_val();
    it.imm_b = rand_val();
    it.line  = 4'($urandom_range(15));
    return it;
  endfunction

  // Offer one instruction until it transfers, then record its expectation
  task automatic send_instr(input instr_t it, input bit fixed, input result_t fixed_res);
    result_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.func        <= it.func;
    in_if.form        <= it.form;
    in_if.first_reg   <= it.ra;
    in_if.second_reg  <= it.rb;
    in_if.imm_a       <= it.imm_a;
    in_if.imm_b       <= it.imm_b;
    in_if.target_line <= it.line;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    pred = exec_instr(it);
    exp_results.push_back(fixed ? fixed_res : pred);
  endtask

  // Receiver: random stalls, or a counted hold-off when requested
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (recv_hold > 0) begin
        out_if.ready <= 1'b0;
        recv_hold--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    result_t act;
    result_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      act.wrote      = out_if.wrote;
      act.dest_index = out_if.dest_index;
      act.dest_value = out_if.dest_value;
      act.redirect   = out_if.redirect;
      act.next_line  = out_if.next_line;
      act.status     = status_e'(out_if.status);
      if (exp_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result transfer wrote=%0b idx=%0d val=%0d redir=%0b line=%0d st=%0d",
                 $realtime, act.wrote, act.dest_index, act.dest_value, act.redirect,
                 act.next_line, act.status);
      end else begin
        exp_r = exp_results.pop_front();
        if (act !== exp_r) begin
          err_count++;
          $display("%0t: mismatch exp wrote=%0b idx=%0d val=%0d redir=%0b line=%0d st=%0d",
                   $realtime, exp_r.wrote, exp_r.dest_index, exp_r.dest_value, exp_r.redirect,
                   exp_r.next_line, exp_r.status);
          $display("%0t:          act wrote=%0b idx=%0d val=%0d redir=%0b line=%0d st=%0d",
                   $realtime, act.wrote, act.dest_index, act.dest_value, act.redirect,
                   act.next_line, act.status);
        end
      end
    end
  end

  // Main sequence
  initial begin
    int unsigned send_mix [5] = '{0, 64, 0, 13, 0};
    int unsigned recv_mix [5] = '{0, 0, 64, 13, 0};
    result_t     none_ok;
    err_count      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    recv_hold      = 0;
    arch_halted    = 1'b0;
    foreach (arch_regs[i]) arch_regs[i] = '0;
    none_ok = mk_res(1'b0, 4'd0, 32'd0, 1'b0, 4'd0, STAT_OK);

    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.func        <= '0;
    in_if.form        <= '0;
    in_if.first_reg   <= '0;
    in_if.second_reg  <= '0;
    in_if.imm_a       <= '0;
    in_if.imm_b       <= '0;
    in_if.target_line <= '0;

    // Directed table; registers start at zero
    row_fix(mk_instr(FUNC_BRANCH, FORM_IMM_IMM, 0, 0, 0, 0, 9),
            mk_res(0, 0, 0, 1, 9, STAT_OK));
    row_fix(mk_instr(FUNC_JUMP, FORM_IMM_IMM, 0, 0, 0, 0, 15),
            mk_res(0, 0, 0, 1, 15, STAT_OK));
    row_fix(mk_instr(FUNC_ADD, FORM_IMM_IMM, 0, 0, 32'h7fff_ffff, 32'd1, 0),
            mk_res(1, 0, 32'h8000_0000, 0, 0, STAT_OK));
    row_fix(mk_instr(FUNC_SUB, FORM_IMM_IMM, 0, 0, 32'h8000_0000, 32'd1, 0),
            mk_res(1, 0, 32'h7fff_ffff, 0, 0, STAT_OK));
    row_fix(mk_instr(FUNC_MUL, FORM_IMM_IMM, 0, 0, 32'hffff_ffff, 32'hffff_ffff, 0),
            mk_res(1, 0, 32'd1, 0, 0, STAT_OK));
    // most negative over -1 wraps
    row_fix(mk_instr(FUNC_DIV, FORM_IMM_IMM, 0, 0, 32'h8000_0000, 32'hffff_ffff, 0),
            mk_res(1, 0, 32'h8000_0000, 0, 0, STAT_OK));
    row_fix(mk_instr(FUNC_DIV, FORM_IMM_IMM, 0, 0, 32'd7, 32'd0, 0),
            mk_res(0, 0, 0, 0, 0, STAT_DIV0));
    row_fix(mk_instr(FUNC_MOVE, FORM_REG_IMM, 9, 0, 0, 32'hffff_ffff, 0),
            mk_res(1, 9, 32'hffff_ffff, 0, 0, STAT_OK));
    row_fix(mk_instr(FUNC_MOVE, FORM_REG_IMM, 15, 0, 0, 32'd5, 0),
            mk_res(0, 0, 0, 0, 0, STAT_BAD_IDX));
    row_chk(mk_instr(FUNC_MOVE, FORM_REG_REG, 3, 9, 0, 0, 0));
    row_fix(mk_instr(FUNC_MOVE, FORM_REG_REG, 2, 10, 0, 0, 0),
            mk_res(0, 0, 0, 0, 0, STAT_BAD_IDX));
    row_fix(mk_instr(FUNC_MOVE, FORM_IMM_IMM, 1, 1, 32'd3, 32'd3, 0), none_ok);
    row_fix(mk_instr(FUNC_MOVE, FormSpare, 1, 1, 32'd3, 32'd3, 0), none_ok);
    row_chk(mk_instr(FUNC_MOVE, FORM_REG_IMM, 4, 0, 0, 32'd7, 0));
    row_chk(mk_instr(FUNC_DIV, FORM_REG_IMM, 4, 0, 0, 32'hffff_fffe, 0));
    row_chk(mk_instr(FUNC_SUB, FORM_REG_IMM, 0, 0, 0, 32'h7fff_ffff, 0));
    row_chk(mk_instr(FUNC_MUL, FORM_REG_REG, 4, 9, 0, 0, 0));
    row_fix(mk_instr(FUNC_ADD, FORM_REG_REG, 12, 0, 0, 0, 0),
            mk_res(0, 0, 0, 0, 0, STAT_BAD_IDX));
    // bad index wins over a zero divisor
    row_fix(mk_instr(FUNC_DIV, FORM_REG_REG, 11, 5, 0, 0, 0),
            mk_res(0, 0, 0, 0, 0, STAT_BAD_IDX));
    row_fix(mk_instr(FUNC_DIV, FORM_REG_REG, 4, 5, 0, 0, 0),
            mk_res(0, 0, 0, 0, 0, STAT_DIV0));
    row_fix(mk_instr(FUNC_ADD, FormSpare, 0, 0, 32'd1, 32'd1, 0), none_ok);
    row_chk(mk_instr(FUNC_CMP, FORM_IMM_IMM, 4, 9, 0, 0, 0));
    row_chk(mk_instr(FUNC_CMP, FormSpare, 3, 9, 0, 0, 0));
    row_chk(mk_instr(FUNC_BRANCH, FORM_IMM_IMM, 0, 0, 0, 0, 6));
    row_chk(mk_instr(FUNC_CMP, FORM_REG_IMM, 9, 4, 0, 0, 0));
    row_chk(mk_instr(FUNC_BRANCH, FORM_IMM_IMM, 0, 0, 0, 0, 3));
    row_fix(mk_instr(FUNC_CMP, FORM_REG_REG, 13, 0, 0, 0, 0),
            mk_res(0, 0, 0, 0, 0, STAT_BAD_IDX));
    row_fix(mk_instr(FuncSpareLo, FORM_IMM_IMM, 0, 0, 32'd1, 32'd1, 1), none_ok);
    row_fix(mk_instr(FuncSpareHi, FORM_REG_REG, 0, 0, 32'd1, 32'd1, 1), none_ok);

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) send_instr(stim_rows[i].ins, stim_rows[i].fixed, stim_rows[i].res);

    // Random streams under each idle mix; the last phase starts with a hold-off
    for (int p = 0; p < 5; p++) begin
      send_idle_pct  = send_mix[p];
      recv_stall_pct = recv_mix[p];
      if (p == 4) recv_hold = LongHold;
      for (int n = 0; n < PhaseItems; n++) send_instr(rand_instr(), 1'b0, '0);
    end

    // Halt, then everything after it reports halted
    send_idle_pct  = 13;
    recv_stall_pct = 13;
    send_instr(mk_instr(FUNC_HALT, FORM_IMM_IMM, 0, 0, 0, 0, 0), 1'b1,
               mk_res(0, 0, 0, 0, 0, STAT_HALTED));
    for (int n = 0; n < HaltTailItems; n++) send_instr(rand_instr(), 1'b0, '0);
    in_if.valid <= 1'b0;

    while (exp_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (err_count == 0) begin
      $display("[tiny_register_machine_execute] OK");
    end else begin
      $display("[tiny_register_machine_execute] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/trm_pkg.sv
sv/trm_in_if.sv
sv/trm_out_if.sv
sv/trm_ram.sv
sv/trm_muldiv.sv
sv/trm_front.sv
sv/trm_queue.sv
sv/trm_back.sv
sv/tiny_register_machine_execute.sv
sv/trm_checker.sv
tb/tb.sv
